/* design/vector_rotate_degrees_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the vector rotation core.
// Immediate-consequence and next-cycle forms of a clocked, reset-gated check.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ROTATE_DEGREES_CORE_ASSERT_SVH
`define VECTOR_ROTATE_DEGREES_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/vrd_pkg.sv */
// ----------------------------------------------------------------------------
// Vector rotation package
// Shared constants, the arctangent table and the rotator stage payload type.
// ----------------------------------------------------------------------------
package vrd_pkg;

  // Angle formats: input in 1/64 degree, reduced angle, wrap arithmetic.
  localparam int ANGLE_WIDTH       = 16;
  localparam int TURN_WIDTH        = 17;
  localparam int RED_WIDTH         = 14;
  localparam int ANGLE_SCALE_SHIFT = 18;

  localparam logic signed [TURN_WIDTH-1:0] FULL_TURN          = 17'sd23040;
  localparam logic signed [TURN_WIDTH-1:0] TWO_TURNS          = 17'sd46080;
  localparam logic signed [TURN_WIDTH-1:0] HALF_TURN          = 17'sd11520;
  localparam logic signed [TURN_WIDTH-1:0] QUARTER_TURN       = 17'sd5760;
  localparam logic signed [TURN_WIDTH-1:0] THREE_QUARTER_TURN = 17'sd17280;

  // Rotator datapath: cosine and sine in Q2.30, residual angle in 2^-24 degree.
  localparam int CS_WIDTH   = 32;
  localparam int Z_WIDTH    = 32;
  localparam int MAG_WIDTH  = 31;
  localparam int TABLE_LEN  = 24;
  localparam int PROD_SHIFT = 15;

  localparam logic signed [CS_WIDTH-1:0] ONE_Q30      = 32'sd1073741824;
  localparam logic signed [CS_WIDTH-1:0] INV_GAIN_Q30 = 32'sd652032874;

  // atan(2^-i) in degrees, scaled by 2^24 and rounded.
  localparam logic signed [Z_WIDTH-1:0] ATAN_DEG_Q24 [TABLE_LEN] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115
  };

  // State of one request as it moves through the rotator stages.
  typedef struct packed {
    logic signed [CS_WIDTH-1:0] c;
    logic signed [CS_WIDTH-1:0] s;
    logic signed [Z_WIDTH-1:0]  z;
    logic                       exact;
    logic                       flip;
  } cordic_t;

endpackage

/* design/vrd_point_if.sv */
// ----------------------------------------------------------------------------
// Point request channel
// Valid/ready channel carrying a Q16.16 point and a rotation angle.
// ----------------------------------------------------------------------------
interface vrd_point_if #(
  parameter int COORD_WIDTH = 32
);
  import vrd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, point_x, point_y, angle, input ready);
  modport sink   (input valid, point_x, point_y, angle, output ready);
endinterface

/* design/vrd_result_if.sv */
// ----------------------------------------------------------------------------
// Rotated point channel
// Valid/ready channel carrying the rotated Q16.16 point.
// ----------------------------------------------------------------------------
interface vrd_result_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rotated_x;
  logic signed [COORD_WIDTH-1:0] rotated_y;

  modport source (output valid, rotated_x, rotated_y, input ready);
  modport sink   (input valid, rotated_x, rotated_y, output ready);
endinterface

/* design/vrd_cordic_step.sv */
// ----------------------------------------------------------------------------
// Rotator step
// One registered CORDIC micro-rotation with a pass-along payload.
// ----------------------------------------------------------------------------
module vrd_cordic_step #(
  parameter int STEP       = 0,
  parameter int PASS_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  vrd_pkg::cordic_t      cord_i,
  input  logic [PASS_WIDTH-1:0] pass_i,
  output logic                  valid_o,
  output vrd_pkg::cordic_t      cord_o,
  output logic [PASS_WIDTH-1:0] pass_o
);
  import vrd_pkg::*;

  logic                       valid_q;
  cordic_t                    cord_d;
  cordic_t                    cord_q;
  logic [PASS_WIDTH-1:0]      pass_q;
  logic signed [CS_WIDTH-1:0] dc;
  logic signed [CS_WIDTH-1:0] ds;

  // Micro-rotation toward zero residual angle; exact axis values pass unchanged.
  always_comb begin
    dc     = $signed(cord_i.s) >>> STEP;
    ds     = $signed(cord_i.c) >>> STEP;
    cord_d = cord_i;
    if (!cord_i.exact) begin
      if (!cord_i.z[Z_WIDTH-1]) begin
        cord_d.c = $signed(cord_i.c) - dc;
        cord_d.s = $signed(cord_i.s) + ds;
        cord_d.z = $signed(cord_i.z) - ATAN_DEG_Q24[STEP];
      end else begin
        cord_d.c = $signed(cord_i.c) + dc;
        cord_d.s = $signed(cord_i.s) - ds;
        cord_d.z = $signed(cord_i.z) + ATAN_DEG_Q24[STEP];
      end
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_q <= cord_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign cord_o  = cord_q;
  assign pass_o  = pass_q;

endmodule

/* design/vector_rotate_degrees_core.sv */
// Throughput: one request per cycle; the pipeline has one register stage for the angle
// reduction, one per CORDIC step, and five for clamping, multiplication and rounding.
// A stall holds only the stages that are full; bubbles ahead of the stall still fill.
// Reset clears the stage valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// Vector rotation core
// Rotates a Q16.16 point counter-clockwise by an angle in 1/64 degree using a
// pipelined CORDIC for sine and cosine, with rounded and saturated products.
// ----------------------------------------------------------------------------
`include "vector_rotate_degrees_core_assert.svh"

module vector_rotate_degrees_core #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vrd_point_if.sink    point_i,
  vrd_result_if.source result_o
);
  import vrd_pkg::*;

  // Stage indexes and datapath widths.
  localparam int S_POST  = ANGLE_STEPS + 1;
  localparam int S_MUL   = ANGLE_STEPS + 2;
  localparam int S_COMB  = ANGLE_STEPS + 3;
  localparam int S_SUM   = ANGLE_STEPS + 4;
  localparam int LAST    = ANGLE_STEPS + 5;
  localparam int PASS_W  = 2 * COORD_WIDTH;
  localparam int TERMS   = 4;
  localparam int LO_W    = (COORD_WIDTH + 1) / 2;
  localparam int HI_W    = COORD_WIDTH - LO_W;
  localparam int PP_LO_W = LO_W + MAG_WIDTH;
  localparam int PP_HI_W = HI_W + MAG_WIDTH;
  localparam int PROD_W  = COORD_WIDTH + MAG_WIDTH;
  localparam int TERM_W  = PROD_W - PROD_SHIFT;
  localparam int SUM_W   = TERM_W + 2;
  localparam int Q_W     = SUM_W - PROD_SHIFT;

  localparam logic signed [SUM_W-1:0] ROUND_HALF =
    SUM_W'(1) << (PROD_SHIFT - 1);
  localparam logic signed [Q_W-1:0] SAT_MAX =
    $signed({{(Q_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}});
  localparam logic signed [Q_W-1:0] SAT_MIN =
    $signed({{(Q_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}});

  // Saturate a rounded sum to the coordinate range.
  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [Q_W-1:0] v);
    logic [COORD_WIDTH-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_WIDTH-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  // Clamp a CORDIC output to the closed unit range.
  function automatic logic signed [CS_WIDTH-1:0] clamp_unit(
    input logic signed [CS_WIDTH-1:0] v
  );
    logic signed [CS_WIDTH-1:0] r;
    if (v > ONE_Q30) begin
      r = ONE_Q30;
    end else if (v < -ONE_Q30) begin
      r = -ONE_Q30;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [LAST:0] stage_valid;
  logic [LAST:0] stage_en;

  // Each stage advances when it is empty or the stage after it advances.
  assign stage_en[LAST] = !stage_valid[LAST] || result_o.ready;
  for (genvar k = 0; k < LAST; k++) begin : g_en
    assign stage_en[k] = !stage_valid[k] || stage_en[k+1];
  end
  assign point_i.ready = stage_en[0];

  // --------------------------------------------------------------------------
  // Angle reduction into [-90, 90] degrees with a half-turn flip.
  // --------------------------------------------------------------------------
  logic signed [TURN_WIDTH-1:0] ang_ext;
  logic signed [TURN_WIDTH-1:0] turn_mod;
  logic signed [TURN_WIDTH-1:0] red_wide;
  logic signed [RED_WIDTH-1:0]  red;
  logic                         red_flip;
  cordic_t                      init_cord;

  always_comb begin
    ang_ext = TURN_WIDTH'(point_i.angle);
    // Wrap into one positive turn.
    if (ang_ext >= FULL_TURN) begin
      turn_mod = ang_ext - FULL_TURN;
    end else if (ang_ext >= 0) begin
      turn_mod = ang_ext;
    end else if (ang_ext >= -FULL_TURN) begin
      turn_mod = ang_ext + FULL_TURN;
    end else begin
      turn_mod = ang_ext + TWO_TURNS;
    end
    // Fold the left half-plane onto the right one.
    if (turn_mod <= QUARTER_TURN) begin
      red_wide = turn_mod;
      red_flip = 1'b0;
    end else if (turn_mod < THREE_QUARTER_TURN) begin
      red_wide = turn_mod - HALF_TURN;
      red_flip = 1'b1;
    end else begin
      red_wide = turn_mod - FULL_TURN;
      red_flip = 1'b0;
    end
    red = red_wide[RED_WIDTH-1:0];

    init_cord.z     = Z_WIDTH'(red) <<< ANGLE_SCALE_SHIFT;
    init_cord.flip  = red_flip;
    init_cord.exact = 1'b1;
    // Exact axes bypass the rotator; other angles start from the gain reciprocal.
    if (red_wide == 0) begin
      init_cord.c = ONE_Q30;
      init_cord.s = '0;
    end else if (red_wide == QUARTER_TURN) begin
      init_cord.c = '0;
      init_cord.s = ONE_Q30;
    end else if (red_wide == -QUARTER_TURN) begin
      init_cord.c = '0;
      init_cord.s = -ONE_Q30;
    end else begin
      init_cord.c     = INV_GAIN_Q30;
      init_cord.s     = '0;
      init_cord.exact = 1'b0;
    end
  end

  cordic_t           cord [0:ANGLE_STEPS];
  logic [PASS_W-1:0] pass [0:ANGLE_STEPS];
  logic              s0_valid_q;
  cordic_t           s0_cord_q;
  logic [PASS_W-1:0] s0_pass_q;

  // Reduction stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (stage_en[0]) begin
      s0_valid_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s0_cord_q <= init_cord;
      s0_pass_q <= {point_i.point_x, point_i.point_y};
    end
  end

  assign stage_valid[0] = s0_valid_q;
  assign cord[0]        = s0_cord_q;
  assign pass[0]        = s0_pass_q;

  // --------------------------------------------------------------------------
  // CORDIC steps, one register stage each.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_step
    vrd_cordic_step #(
      .STEP      (i),
      .PASS_WIDTH(PASS_W)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (stage_en[i+1]),
      .valid_i(stage_valid[i]),
      .cord_i (cord[i]),
      .pass_i (pass[i]),
      .valid_o(stage_valid[i+1]),
      .cord_o (cord[i+1]),
      .pass_o (pass[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Clamp, apply the flip and split everything into sign and magnitude.
  // --------------------------------------------------------------------------
  logic signed [CS_WIDTH-1:0]    c_cl;
  logic signed [CS_WIDTH-1:0]    s_cl;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;

  logic                   a_valid_q;
  logic [COORD_WIDTH-1:0] a_xm_q;
  logic [COORD_WIDTH-1:0] a_ym_q;
  logic [MAG_WIDTH-1:0]   a_cm_q;
  logic [MAG_WIDTH-1:0]   a_sm_q;
  logic                   a_xn_q;
  logic                   a_yn_q;
  logic                   a_cn_q;
  logic                   a_sn_q;

  always_comb begin
    c_cl = clamp_unit(cord[ANGLE_STEPS].c);
    s_cl = clamp_unit(cord[ANGLE_STEPS].s);
    x_in = $signed(pass[ANGLE_STEPS][PASS_W-1:COORD_WIDTH]);
    y_in = $signed(pass[ANGLE_STEPS][COORD_WIDTH-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (stage_en[S_POST]) begin
      a_valid_q <= stage_valid[ANGLE_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[S_POST]) begin
      a_xm_q <= x_in[COORD_WIDTH-1] ? COORD_WIDTH'(-x_in) : COORD_WIDTH'(x_in);
      a_ym_q <= y_in[COORD_WIDTH-1] ? COORD_WIDTH'(-y_in) : COORD_WIDTH'(y_in);
      a_cm_q <= c_cl[CS_WIDTH-1] ? MAG_WIDTH'(-c_cl) : MAG_WIDTH'(c_cl);
      a_sm_q <= s_cl[CS_WIDTH-1] ? MAG_WIDTH'(-s_cl) : MAG_WIDTH'(s_cl);
      a_xn_q <= x_in[COORD_WIDTH-1];
      a_yn_q <= y_in[COORD_WIDTH-1];
      a_cn_q <= c_cl[CS_WIDTH-1] ^ cord[ANGLE_STEPS].flip;
      a_sn_q <= s_cl[CS_WIDTH-1] ^ cord[ANGLE_STEPS].flip;
    end
  end

  assign stage_valid[S_POST] = a_valid_q;

  // --------------------------------------------------------------------------
  // Partial products: each coordinate magnitude is split into two halves.
  // Terms: x*c, y*(-s) for rotated x; x*s, y*c for rotated y.
  // --------------------------------------------------------------------------
  logic [COORD_WIDTH-1:0] mul_a [TERMS];
  logic [MAG_WIDTH-1:0]   mul_b [TERMS];
  logic [TERMS-1:0]       mul_neg;

  always_comb begin
    mul_a[0]   = a_xm_q;
    mul_b[0]   = a_cm_q;
    mul_neg[0] = a_xn_q ^ a_cn_q;
    mul_a[1]   = a_ym_q;
    mul_b[1]   = a_sm_q;
    mul_neg[1] = ~(a_yn_q ^ a_sn_q);
    mul_a[2]   = a_xm_q;
    mul_b[2]   = a_sm_q;
    mul_neg[2] = a_xn_q ^ a_sn_q;
    mul_a[3]   = a_ym_q;
    mul_b[3]   = a_cm_q;
    mul_neg[3] = a_yn_q ^ a_cn_q;
  end

  logic               b_valid_q;
  logic [PP_LO_W-1:0] b_lo_q [TERMS];
  logic [PP_HI_W-1:0] b_hi_q [TERMS];
  logic [TERMS-1:0]   b_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (stage_en[S_MUL]) begin
      b_valid_q <= stage_valid[S_POST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[S_MUL]) begin
      for (int t = 0; t < TERMS; t++) begin
        b_lo_q[t] <= PP_LO_W'(mul_a[t][LO_W-1:0]) * PP_LO_W'(mul_b[t]);
        b_hi_q[t] <= PP_HI_W'(mul_a[t][COORD_WIDTH-1:LO_W]) * PP_HI_W'(mul_b[t]);
      end
      b_neg_q <= mul_neg;
    end
  end

  assign stage_valid[S_MUL] = b_valid_q;

  // --------------------------------------------------------------------------
  // Combine the halves and drop the low product bits (magnitude floor).
  // --------------------------------------------------------------------------
  logic              c_valid_q;
  logic [TERM_W-1:0] c_term_q [TERMS];
  logic [TERMS-1:0]  c_neg_q;
  logic [PROD_W-1:0] prod_full [TERMS];

  always_comb begin
    for (int t = 0; t < TERMS; t++) begin
      prod_full[t] = (PROD_W'(b_hi_q[t]) << LO_W) + PROD_W'(b_lo_q[t]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (stage_en[S_COMB]) begin
      c_valid_q <= stage_valid[S_MUL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[S_COMB]) begin
      for (int t = 0; t < TERMS; t++) begin
        c_term_q[t] <= prod_full[t][PROD_W-1:PROD_SHIFT];
      end
      c_neg_q <= b_neg_q;
    end
  end

  assign stage_valid[S_COMB] = c_valid_q;

  // --------------------------------------------------------------------------
  // Signed sums with the rounding half added.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] term_s [TERMS];

  always_comb begin
    for (int t = 0; t < TERMS; t++) begin
      term_s[t] = $signed(SUM_W'(c_term_q[t]));
      if (c_neg_q[t]) begin
        term_s[t] = -term_s[t];
      end
    end
  end

  logic                    d_valid_q;
  logic signed [SUM_W-1:0] d_sum_x_q;
  logic signed [SUM_W-1:0] d_sum_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (stage_en[S_SUM]) begin
      d_valid_q <= stage_valid[S_COMB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[S_SUM]) begin
      d_sum_x_q <= term_s[0] + term_s[1] + ROUND_HALF;
      d_sum_y_q <= term_s[2] + term_s[3] + ROUND_HALF;
    end
  end

  assign stage_valid[S_SUM] = d_valid_q;

  // --------------------------------------------------------------------------
  // Output register: floor shift to Q16.16 and saturate.
  // --------------------------------------------------------------------------
  logic signed [Q_W-1:0]  q_x;
  logic signed [Q_W-1:0]  q_y;
  logic                   e_valid_q;
  logic [COORD_WIDTH-1:0] e_x_q;
  logic [COORD_WIDTH-1:0] e_y_q;

  assign q_x = $signed(d_sum_x_q[SUM_W-1:PROD_SHIFT]);
  assign q_y = $signed(d_sum_y_q[SUM_W-1:PROD_SHIFT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (stage_en[LAST]) begin
      e_valid_q <= stage_valid[S_SUM];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[LAST]) begin
      e_x_q <= sat_coord(q_x);
      e_y_q <= sat_coord(q_y);
    end
  end

  assign stage_valid[LAST]  = e_valid_q;
  assign result_o.valid     = e_valid_q;
  assign result_o.rotated_x = $signed(e_x_q);
  assign result_o.rotated_y = $signed(e_y_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `VRD_ASSERT_IMPL(a_no_bubble_stall, clk_i, rst_ni, !point_i.ready, &stage_valid,
    "Input stalled although the pipeline holds a bubble.")
  `VRD_ASSERT_NEXT(a_post_hold, clk_i, rst_ni, stage_valid[S_POST] && !stage_en[S_POST],
    stage_valid[S_POST] && $stable(a_cm_q) && $stable(a_xm_q),
    "A stalled clamp stage lost or changed its request.")
  `VRD_ASSERT_IMPL(a_unit_magnitude, clk_i, rst_ni, stage_valid[S_POST],
    (a_cm_q <= MAG_WIDTH'(ONE_Q30)) && (a_sm_q <= MAG_WIDTH'(ONE_Q30)),
    "Cosine or sine magnitude exceeds one after clamping.")
  `VRD_ASSERT_IMPL(a_exact_axis, clk_i, rst_ni,
    stage_valid[ANGLE_STEPS] && cord[ANGLE_STEPS].exact,
    ((cord[ANGLE_STEPS].c == ONE_Q30) && (cord[ANGLE_STEPS].s == 0)) ||
    ((cord[ANGLE_STEPS].c == 0) &&
     ((cord[ANGLE_STEPS].s == ONE_Q30) || (cord[ANGLE_STEPS].s == -ONE_Q30))),
    "Exact axis request left the rotator with inexact cosine or sine.")

endmodule
